@@ design/cxr_pkg.sv @@
// Shared types, fixed-point constants and saturation helper for the
// CIE xy to RGB converter. No dependencies.
package cxr_pkg;

  typedef struct packed {
    logic [15:0] chroma_x;
    logic [15:0] chroma_y;
  } chroma_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       bad_input;
  } color_t;

  // Signed Q8.16 working format
  localparam int Q_W = 24;
  localparam logic signed [47:0] Q_MAX = 48'sd8388607;
  localparam logic signed [47:0] Q_MIN = -48'sd8388608;

  // Pipeline unit sizes (one result bit per stage)
  localparam int XZ_QUO_W  = 23;  // X and Z quotient bits below saturation
  localparam int SQ1_W     = 20;  // sqrt(c << 16)
  localparam int SQ2_W     = 18;  // sqrt(s1 << 16)
  localparam int CB_W      = 19;  // cube roots of values below 2^57
  localparam int OUT_QUO_W = 8;   // channel * 255 / max

  // XYZ to linear RGB matrix, Q.16 magnitudes
  localparam logic signed [17:0] MRX = 18'sd95866;
  localparam logic signed [17:0] MRZ = 18'sd17980;
  localparam logic signed [17:0] MGX = 18'sd34196;
  localparam logic signed [17:0] MGZ = 18'sd4438;
  localparam logic signed [17:0] MBX = 18'sd2289;
  localparam logic signed [17:0] MBZ = 18'sd84437;
  // Y = 1.0 terms, already scaled by 2^16
  localparam logic signed [43:0] OFS_R = 44'sd790560768;
  localparam logic signed [43:0] OFS_G = 44'sd6215827456;
  localparam logic signed [43:0] OFS_B = 44'sd416153600;

  // sRGB transfer curve
  localparam logic signed [23:0] LIN_LIMIT  = 24'sd205;
  localparam logic signed [20:0] LIN_SLOPE  = 21'sd846725;
  localparam logic [16:0]        GAMMA_GAIN = 17'd69140;
  localparam logic signed [47:0] GAMMA_OFS  = 48'sd3604;

  function automatic logic signed [23:0] sat_q(input logic signed [47:0] v);
    logic signed [23:0] res;
    if (v > Q_MAX) begin
      res = Q_MAX[23:0];
    end else if (v < Q_MIN) begin
      res = Q_MIN[23:0];
    end else begin
      res = v[23:0];
    end
    return res;
  endfunction

endpackage

@@ design/cxr_delay.sv @@
// Enable-gated shift line that aligns side data with pipelined units.
// No dependencies.
module cxr_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

@@ design/cxr_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Requires dividend >> QUO_W to be below the divisor. No dependencies.
module cxr_div_pipe #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 16,
  parameter int QUO_W = 23
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient
);

  logic [DVS_W-1:0] rem_r [QUO_W];
  logic [QUO_W-1:0] low_r [QUO_W];
  logic [QUO_W-1:0] quo_r [QUO_W];
  logic [DVS_W-1:0] dvs_r [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [DVS_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    logic [DVS_W-1:0] dvs_in;
    logic [DVS_W:0]   trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = DVS_W'(dividend[DVD_W-1:QUO_W]);
      assign low_in = dividend[QUO_W-1:0];
      assign quo_in = '0;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign low_in = low_r[i-1];
      assign quo_in = quo_r[i-1];
      assign dvs_in = dvs_r[i-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1-i]};
    assign ge    = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? DVS_W'(trial - {1'b0, dvs_in}) : DVS_W'(trial);
        low_r[i] <= low_in;
        quo_r[i] <= {quo_in[QUO_W-2:0], ge};
        dvs_r[i] <= dvs_in;
      end
    end
  end

  assign quotient = quo_r[QUO_W-1];

endmodule

@@ design/cxr_isqrt_pipe.sv @@
// Pipelined floor square root, one root bit per stage.
// No dependencies.
module cxr_isqrt_pipe #(
  parameter int ROOT_W = 20
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root
);

  localparam int REM_W = ROOT_W + 2;
  localparam int SH_W  = REM_W + 2;

  logic [REM_W-1:0]    rem_r  [ROOT_W];
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [2*ROOT_W-1:0] rad_r  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]    rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] rad_in;
    logic [SH_W-1:0]     sh;
    logic [SH_W-1:0]     trial;
    logic                ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
    end

    assign sh    = {rem_in, rad_in[2*(ROOT_W-1-i) +: 2]};
    assign trial = SH_W'({root_in, 2'b01});
    assign ge    = sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? REM_W'(sh - trial) : REM_W'(sh);
        root_r[i] <= {root_in[ROOT_W-2:0], ge};
        rad_r[i]  <= rad_in;
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

@@ design/cxr_icbrt_pipe.sv @@
// Pipelined floor cube root, one root bit per stage; the square of the
// partial root is tracked so no stage needs a multiplier. No dependencies.
module cxr_icbrt_pipe #(
  parameter int ROOT_W = 19
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [3*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root
);

  localparam int SQ_W  = 2 * ROOT_W;
  localparam int REM_W = 2 * ROOT_W + 2;
  localparam int W     = REM_W + 3;

  logic [REM_W-1:0]    rem_r  [ROOT_W];
  logic [ROOT_W-1:0]   root_r [ROOT_W];
  logic [SQ_W-1:0]     sq_r   [ROOT_W];
  logic [3*ROOT_W-1:0] rad_r  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]    rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [SQ_W-1:0]     sq_in;
    logic [3*ROOT_W-1:0] rad_in;
    logic [W-1:0]        sh;
    logic [W-1:0]        t;
    logic [W-1:0]        step;
    logic [W-1:0]        sq_up;
    logic                ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign sq_in   = '0;
      assign rad_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign sq_in   = sq_r[i-1];
      assign rad_in  = rad_r[i-1];
    end

    // (2y+1)^3 - (2y)^3 = 3 * (4y^2 + 2y) + 1
    assign sh    = {rem_in, rad_in[3*(ROOT_W-1-i) +: 3]};
    assign t     = W'({sq_in, 2'b00}) + W'({root_in, 1'b0});
    assign step  = t + (t << 1) + W'(1);
    assign sq_up = W'({sq_in, 2'b00}) + W'({root_in, 2'b00}) + W'(1);
    assign ge    = sh >= step;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? REM_W'(sh - step) : REM_W'(sh);
        root_r[i] <= {root_in[ROOT_W-2:0], ge};
        sq_r[i]   <= ge ? SQ_W'(sq_up) : SQ_W'({sq_in, 2'b00});
        rad_r[i]  <= rad_in;
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

@@ design/cie_xy_to_rgb_converter.sv @@
// Top level of the CIE xy to 8-bit RGB converter pipeline.
// Depends on cxr_pkg, cxr_delay, cxr_div_pipe, cxr_isqrt_pipe, cxr_icbrt_pipe.
//
// Usage:
//   Input channel pair_valid / pair_stall / pair carries one chromaticity
//   transaction (chroma_x, chroma_y, UQ0.COORD_BITS). Output channel
//   color_valid / color_stall / color returns one transaction per input:
//   red, green, blue and the bad_input flag.
//   The latency from acceptance to color_valid is set mostly by the
//   bit-serial X/Z dividers (23 stages), the root chain of the transfer
//   curve (sqrt 20 + sqrt 18 + cube root 19 stages) and the final
//   normalizing divider (8 stages).
//   Throughput is one transaction per clock unless stalled; any valid pattern
//   is accepted. The whole pipeline advances together; it holds only when the
//   output register has a transaction and color_stall is high, and pair_stall
//   mirrors exactly that condition. Nothing is dropped or repeated.
//   Synchronous rst clears all valid bits; data registers are not reset.
//   There is no state across transactions and no configuration.
module cie_xy_to_rgb_converter #(
  parameter int COORD_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pair_valid,
  output logic             pair_stall,
  input  cxr_pkg::chroma_t pair,
  output logic             color_valid,
  input  logic             color_stall,
  output cxr_pkg::color_t  color
);

  localparam int QW       = cxr_pkg::Q_W;
  localparam int ROOT_LAT = cxr_pkg::SQ1_W + cxr_pkg::SQ2_W + cxr_pkg::CB_W;
  localparam int LAT      = 10 + cxr_pkg::XZ_QUO_W + ROOT_LAT + cxr_pkg::OUT_QUO_W;
  localparam int SHR      = (COORD_BITS > 16) ? COORD_BITS - 16 : 0;
  localparam int SHL      = (COORD_BITS < 16) ? 16 - COORD_BITS : 0;

  // ---------------------------------------------------------------------
  // Flow control: one global advance, valid bits ride a shift line
  // ---------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld;

  assign en          = !(vld[LAT-1] && color_stall);
  assign pair_stall  = !en;
  assign color_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pair_valid};
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: capture, rescale the coordinates to Q.16
  // ---------------------------------------------------------------------
  logic [15:0] x0, y0;

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= (pair.chroma_x >> SHR) << SHL;
      y0 <= (pair.chroma_y >> SHR) << SHL;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: z = 1 - x - y, saturation pre-checks for X and Z
  // ---------------------------------------------------------------------
  logic signed [17:0] z0;
  logic [16:0]        zmag0;
  logic [15:0]        x1, y1;
  logic [16:0]        zmag1;
  logic               zneg1, ovx1, ovz1, bad1;

  assign z0    = 18'sd65536 - $signed({2'b00, x0}) - $signed({2'b00, y0});
  assign zmag0 = z0[17] ? 17'(-z0) : z0[16:0];

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= x0;
      y1    <= y0;
      zmag1 <= zmag0;
      zneg1 <= z0[17];
      // Quotient reaches 2^23 exactly when the numerator is 128 * y or more
      ovx1  <= {7'd0, x0} >= {y0, 7'd0};
      ovz1  <= {6'd0, zmag0} >= {y0, 7'd0};
      bad1  <= (y0 == 16'd0);
    end
  end

  // ---------------------------------------------------------------------
  // X = x / y and |Z| = |z| / y, bit-serial dividers
  // ---------------------------------------------------------------------
  logic [cxr_pkg::XZ_QUO_W-1:0] qx, qz;
  logic ovx_d, ovz_d, zneg_d, bad_d;

  cxr_div_pipe #(.DVD_W(32), .DVS_W(16), .QUO_W(cxr_pkg::XZ_QUO_W)) u_div_x (
    .clk(clk), .en(en), .dividend({x1, 16'd0}), .divisor(y1), .quotient(qx)
  );

  cxr_div_pipe #(.DVD_W(33), .DVS_W(16), .QUO_W(cxr_pkg::XZ_QUO_W)) u_div_z (
    .clk(clk), .en(en), .dividend({zmag1, 16'd0}), .divisor(y1), .quotient(qz)
  );

  cxr_delay #(.WIDTH(4), .DEPTH(cxr_pkg::XZ_QUO_W)) u_dly_xz (
    .clk(clk), .en(en),
    .d({ovx1, ovz1, zneg1, bad1}),
    .q({ovx_d, ovz_d, zneg_d, bad_d})
  );

  // Saturate and restore the sign of Z
  logic signed [QW-1:0] bigx, bigz;
  logic                 bad2;

  always_ff @(posedge clk) begin
    if (en) begin
      bigx <= ovx_d ? cxr_pkg::Q_MAX[QW-1:0] : $signed({1'b0, qx});
      if (ovz_d) begin
        bigz <= zneg_d ? cxr_pkg::Q_MIN[QW-1:0] : cxr_pkg::Q_MAX[QW-1:0];
      end else begin
        bigz <= zneg_d ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
      end
      bad2 <= bad_d;
    end
  end

  // ---------------------------------------------------------------------
  // Matrix: products, then sum / floor shift / saturate
  // ---------------------------------------------------------------------
  logic signed [41:0] p_rx, p_rz, p_gx, p_gz, p_bx, p_bz;
  logic               bad3;

  always_ff @(posedge clk) begin
    if (en) begin
      p_rx <= bigx * cxr_pkg::MRX;
      p_rz <= bigz * cxr_pkg::MRZ;
      p_gx <= bigx * cxr_pkg::MGX;
      p_gz <= bigz * cxr_pkg::MGZ;
      p_bx <= bigx * cxr_pkg::MBX;
      p_bz <= bigz * cxr_pkg::MBZ;
      bad3 <= bad2;
    end
  end

  logic signed [43:0]   sum_r, sum_g, sum_b;
  logic signed [QW-1:0] lin [3];
  logic                 bad4;

  assign sum_r = 44'(p_rx) - 44'(p_rz) - cxr_pkg::OFS_R;
  assign sum_g = cxr_pkg::OFS_G - 44'(p_gx) + 44'(p_gz);
  assign sum_b = 44'(p_bx) - cxr_pkg::OFS_B + 44'(p_bz);

  always_ff @(posedge clk) begin
    if (en) begin
      lin[0] <= cxr_pkg::sat_q(48'(sum_r >>> 16));
      lin[1] <= cxr_pkg::sat_q(48'(sum_g >>> 16));
      lin[2] <= cxr_pkg::sat_q(48'(sum_b >>> 16));
      bad4   <= bad3;
    end
  end

  // ---------------------------------------------------------------------
  // Transfer curve per channel: c^(1/2.4) = cbrt(c) * cbrt(sqrt(sqrt(c)))
  // ---------------------------------------------------------------------
  logic bad5, bad6, bad7, bad8;

  cxr_delay #(.WIDTH(1), .DEPTH(ROOT_LAT)) u_dly_bad_curve (
    .clk(clk), .en(en), .d(bad4), .q(bad5)
  );

  logic signed [QW-1:0] curve [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_curve
    logic [22:0]               c_u;
    logic [cxr_pkg::SQ1_W-1:0] s1;
    logic [cxr_pkg::SQ2_W-1:0] s2;
    logic [cxr_pkg::CB_W-1:0]  root_a, root_a_d, root_b;
    logic signed [QW-1:0]      c_d;
    logic [37:0]               ab;
    logic signed [44:0]        lin_p;
    logic                      le_p, le_q;
    logic [38:0]               gq;
    logic signed [QW-1:0]      lin_s;

    // Negative values feed zero into the roots; their result is unused
    assign c_u = lin[ch][QW-1] ? 23'd0 : lin[ch][22:0];

    cxr_icbrt_pipe #(.ROOT_W(cxr_pkg::CB_W)) u_cbrt_a (
      .clk(clk), .en(en), .radicand({2'b00, c_u, 32'd0}), .root(root_a)
    );

    cxr_delay #(.WIDTH(cxr_pkg::CB_W), .DEPTH(ROOT_LAT - cxr_pkg::CB_W)) u_dly_a (
      .clk(clk), .en(en), .d(root_a), .q(root_a_d)
    );

    cxr_isqrt_pipe #(.ROOT_W(cxr_pkg::SQ1_W)) u_sqrt1 (
      .clk(clk), .en(en), .radicand({1'b0, c_u, 16'd0}), .root(s1)
    );

    cxr_isqrt_pipe #(.ROOT_W(cxr_pkg::SQ2_W)) u_sqrt2 (
      .clk(clk), .en(en), .radicand({s1, 16'd0}), .root(s2)
    );

    cxr_icbrt_pipe #(.ROOT_W(cxr_pkg::CB_W)) u_cbrt_b (
      .clk(clk), .en(en), .radicand({7'd0, s2, 32'd0}), .root(root_b)
    );

    cxr_delay #(.WIDTH(QW), .DEPTH(ROOT_LAT)) u_dly_c (
      .clk(clk), .en(en), .d(lin[ch]), .q(c_d)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        ab    <= root_a_d * root_b;
        lin_p <= c_d * cxr_pkg::LIN_SLOPE;
        le_p  <= c_d <= cxr_pkg::LIN_LIMIT;
        gq    <= ab[37:16] * cxr_pkg::GAMMA_GAIN;
        lin_s <= cxr_pkg::sat_q(48'(lin_p >>> 16));
        le_q  <= le_p;
        curve[ch] <= le_q ? lin_s
                   : cxr_pkg::sat_q(48'(signed'({1'b0, gq[38:16]})) - cxr_pkg::GAMMA_OFS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad6 <= bad5;
      bad7 <= bad6;
      bad8 <= bad7;
    end
  end

  // ---------------------------------------------------------------------
  // Normalize by the largest channel and scale to 0..255
  // ---------------------------------------------------------------------
  logic signed [QW-1:0] m_rg, m_all;
  logic [QW-1:0]        m_r;
  logic [31:0]          dvd [3];
  logic [2:0]           neg9, neg_d;
  logic                 bad9, bad_out;
  logic [cxr_pkg::OUT_QUO_W-1:0] qo [3];

  assign m_rg  = (curve[0] > curve[1]) ? curve[0] : curve[1];
  assign m_all = (m_rg > curve[2]) ? m_rg : curve[2];

  always_ff @(posedge clk) begin
    if (en) begin
      m_r  <= m_all;
      bad9 <= bad8 || m_all[QW-1] || (m_all == '0);
      for (int ch = 0; ch < 3; ch++) begin
        neg9[ch] <= curve[ch][QW-1];
        dvd[ch]  <= curve[ch][QW-1] ? 32'd0
                  : 32'({curve[ch][22:0], 8'd0}) - 32'(curve[ch][22:0]);
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_norm
    cxr_div_pipe #(.DVD_W(32), .DVS_W(QW), .QUO_W(cxr_pkg::OUT_QUO_W)) u_div_n (
      .clk(clk), .en(en), .dividend(dvd[ch]), .divisor(m_r), .quotient(qo[ch])
    );
  end

  cxr_delay #(.WIDTH(4), .DEPTH(cxr_pkg::OUT_QUO_W)) u_dly_norm (
    .clk(clk), .en(en), .d({neg9, bad9}), .q({neg_d, bad_out})
  );

  // Output register: negative channels read as full scale, errors as zero
  always_ff @(posedge clk) begin
    if (en) begin
      color.red       <= bad_out ? 8'd0 : (neg_d[0] ? 8'd255 : qo[0]);
      color.green     <= bad_out ? 8'd0 : (neg_d[1] ? 8'd255 : qo[1]);
      color.blue      <= bad_out ? 8'd0 : (neg_d[2] ? 8'd255 : qo[2]);
      color.bad_input <= bad_out;
    end
  end

endmodule

@@ design/cxr_checker.sv @@
// Port-level checks on the converter's output channel, bound to the top.
// Depends on cxr_pkg and cie_xy_to_rgb_converter.
module cxr_checker (
  input logic            clk,
  input logic            rst,
  input logic            color_valid,
  input logic            color_stall,
  input cxr_pkg::color_t color
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !color_valid)
    else $error("output valid right after reset");

  // Stalled output transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    color_valid && color_stall |=> color_valid && $stable(color))
    else $error("stalled output changed");

  // Error results carry zero colors
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    color_valid && color.bad_input |->
      color.red == 8'd0 && color.green == 8'd0 && color.blue == 8'd0)
    else $error("bad_input with nonzero color");

  // The largest channel always normalizes to full scale
  a_full_scale: assert property (@(posedge clk) disable iff (rst)
    color_valid && !color.bad_input |->
      color.red == 8'd255 || color.green == 8'd255 || color.blue == 8'd255)
    else $error("no channel at full scale");

endmodule

bind cie_xy_to_rgb_converter cxr_checker u_cxr_checker (
  .clk(clk),
  .rst(rst),
  .color_valid(color_valid),
  .color_stall(color_stall),
  .color(color)
);
